FILE: rtl/core/rusi_pkg.sv
// shared types, widths and helpers for the ray / unit sphere intersect pipeline
package rusi_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;

  localparam int A_W    = 2 * WORD_BITS;               // a = d.d, unsigned
  localparam int H_W    = 2 * WORD_BITS + 2;           // h = d.o and c = o.o - 1, signed
  localparam int D2_W   = 4 * WORD_BITS;               // h*h and a*|c|
  localparam int X_W    = D2_W + 2 * FRAC_BITS;        // radicand
  localparam int S_W    = X_W / 2;                     // square root
  localparam int REM_W  = S_W + 2;                     // square root remainder
  localparam int N_W    = 2 * WORD_BITS + FRAC_BITS + 3; // signed numerator
  localparam int NM_W   = N_W - 1;                     // numerator magnitude
  localparam int CMP_W  = 3 * WORD_BITS + FRAC_BITS + 2;
  localparam int SQ_CELLS = S_W;
  localparam int DV_CELLS = WORD_BITS;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] ox;
    logic signed [WORD_BITS-1:0] oy;
    logic signed [WORD_BITS-1:0] oz;
    logic signed [WORD_BITS-1:0] dx;
    logic signed [WORD_BITS-1:0] dy;
    logic signed [WORD_BITS-1:0] dz;
  } ray_t;

  typedef struct packed {
    logic                  vld;
    logic [REM_W-1:0]      rem;
    logic [S_W-1:0]        root;
    logic [X_W-1:0]        x;
    logic signed [H_W-1:0] h;
    logic [A_W-1:0]        a;
    logic                  degen;
    logic                  miss;
  } sq_t;

  typedef struct packed {
    logic [A_W-1:0]       rem;
    logic [WORD_BITS-1:0] lo;
    logic [WORD_BITS-1:0] q;
    logic                 neg;
    logic                 ovf;
  } dv_lane_t;

  typedef struct packed {
    logic           vld;
    logic [A_W-1:0] a;
    logic           degen;
    logic           miss;
    dv_lane_t       n;
    dv_lane_t       f;
  } dv_t;

  // one restoring division step: bring in the next numerator bit
  function automatic dv_lane_t div_step(dv_lane_t l, logic [A_W-1:0] dvs);
    logic [A_W:0] t;
    dv_lane_t     r;
    r = l;
    t = {l.rem, l.lo[WORD_BITS-1]};
    if (t >= {1'b0, dvs}) begin
      r.rem = A_W'(t - {1'b0, dvs});
      r.q   = {l.q[WORD_BITS-2:0], 1'b1};
    end else begin
      r.rem = t[A_W-1:0];
      r.q   = {l.q[WORD_BITS-2:0], 1'b0};
    end
    r.lo = l.lo << 1;
    return r;
  endfunction

endpackage

FILE: rtl/core/ray_unit_sphere_intersect.sv
// top level: ray against unit sphere, fully pipelined
//
//  channel  ports                      handshake
//  request  start, busy, in_*          taken when start && !busy
//  result   out_valid, out_*           one-cycle strobe, no backpressure
//
// one request per cycle, results leave in the order the requests are taken
// pipeline: 6 coefficient stages, 80 root cells, 3 numerator stages,
// 32 quotient cells and the output register
// busy stays low; the pipeline never stalls
// synchronous active-low reset clears only the valid pipeline
module ray_unit_sphere_intersect (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [rusi_pkg::WORD_BITS-1:0] in_origin_x,
  input  logic signed [rusi_pkg::WORD_BITS-1:0] in_origin_y,
  input  logic signed [rusi_pkg::WORD_BITS-1:0] in_origin_z,
  input  logic signed [rusi_pkg::WORD_BITS-1:0] in_dir_x,
  input  logic signed [rusi_pkg::WORD_BITS-1:0] in_dir_y,
  input  logic signed [rusi_pkg::WORD_BITS-1:0] in_dir_z,
  output logic                                  out_valid,
  output logic                                  out_hit,
  output logic signed [rusi_pkg::WORD_BITS-1:0] out_t_near,
  output logic signed [rusi_pkg::WORD_BITS-1:0] out_t_far,
  output logic                                  out_degenerate,
  output logic                                  out_saturated
);
  import rusi_pkg::*;

  localparam logic [WORD_BITS-1:0] T_MAX = {1'b0, {(WORD_BITS - 1){1'b1}}};
  localparam logic [WORD_BITS-1:0] T_MIN = {1'b1, {(WORD_BITS - 1){1'b0}}};
  localparam logic [WORD_BITS:0]   NEG_LIM = (WORD_BITS + 1)'(1) << (WORD_BITS - 1);

  ray_t ray;
  sq_t  sq_chain [SQ_CELLS+1];
  dv_t  dv_chain [DV_CELLS+1];

  assign busy = 1'b0;
  assign ray  = '{ox: in_origin_x, oy: in_origin_y, oz: in_origin_z,
                  dx: in_dir_x, dy: in_dir_y, dz: in_dir_z};

  rusi_quad u_quad (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (start && !busy),
    .ray_i (ray),
    .sq_o  (sq_chain[0])
  );

  for (genvar i = 0; i < SQ_CELLS; i++) begin : g_sqrt
    rusi_sqrt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .c_i   (sq_chain[i]),
      .c_o   (sq_chain[i+1])
    );
  end

  // numerators -h*2^f -/+ s, then sign and magnitude, then division setup
  logic [2:0]            pv_r;
  logic signed [N_W-1:0] hs;
  logic signed [N_W-1:0] pn_r, pf_r;
  logic [NM_W-1:0]       mn_r, mf_r;
  logic                  ngn_r, ngf_r;
  logic [A_W-1:0]        pa1_r, pa2_r;
  logic                  pdeg1_r, pdeg2_r, pmiss1_r, pmiss2_r;
  logic signed [N_W-1:0] an, af;
  dv_t                   dv0_r;

  assign hs = -(N_W'(sq_chain[SQ_CELLS].h) <<< FRAC_BITS);
  assign an = pn_r[N_W-1] ? -pn_r : pn_r;
  assign af = pf_r[N_W-1] ? -pf_r : pf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= '0;
    end else begin
      pv_r <= {pv_r[1:0], sq_chain[SQ_CELLS].vld};
    end
  end

  always_ff @(posedge clk) begin
    pn_r     <= hs - N_W'(sq_chain[SQ_CELLS].root);
    pf_r     <= hs + N_W'(sq_chain[SQ_CELLS].root);
    pa1_r    <= sq_chain[SQ_CELLS].a;
    pdeg1_r  <= sq_chain[SQ_CELLS].degen;
    pmiss1_r <= sq_chain[SQ_CELLS].miss;

    mn_r     <= an[NM_W-1:0];
    mf_r     <= af[NM_W-1:0];
    ngn_r    <= pn_r[N_W-1];
    ngf_r    <= pf_r[N_W-1];
    pa2_r    <= pa1_r;
    pdeg2_r  <= pdeg1_r;
    pmiss2_r <= pmiss1_r;

    dv0_r.vld   <= 1'b0;
    dv0_r.a     <= pa2_r;
    dv0_r.degen <= pdeg2_r;
    dv0_r.miss  <= pmiss2_r;
    dv0_r.n.rem <= A_W'(mn_r >> WORD_BITS);
    dv0_r.n.lo  <= mn_r[WORD_BITS-1:0];
    dv0_r.n.q   <= '0;
    dv0_r.n.neg <= ngn_r;
    dv0_r.n.ovf <= CMP_W'(mn_r) >= (CMP_W'(pa2_r) << WORD_BITS);
    dv0_r.f.rem <= A_W'(mf_r >> WORD_BITS);
    dv0_r.f.lo  <= mf_r[WORD_BITS-1:0];
    dv0_r.f.q   <= '0;
    dv0_r.f.neg <= ngf_r;
    dv0_r.f.ovf <= CMP_W'(mf_r) >= (CMP_W'(pa2_r) << WORD_BITS);
  end

  always_comb begin
    dv_chain[0]     = dv0_r;
    dv_chain[0].vld = pv_r[2];
  end

  for (genvar j = 0; j < DV_CELLS; j++) begin : g_div
    rusi_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .c_i   (dv_chain[j]),
      .c_o   (dv_chain[j+1])
    );
  end

  // floor, sign and clamp of both quotients
  dv_t                  dv_end;
  logic [WORD_BITS:0]   mn_q, mf_q;
  logic [WORD_BITS-1:0] tn, tf;
  logic                 sn, sf, hit;

  assign dv_end = dv_chain[DV_CELLS];
  assign mn_q = {1'b0, dv_end.n.q} + (WORD_BITS + 1)'(dv_end.n.rem != '0);
  assign mf_q = {1'b0, dv_end.f.q} + (WORD_BITS + 1)'(dv_end.f.rem != '0);
  assign hit  = !dv_end.degen && !dv_end.miss;

  always_comb begin
    sn = 1'b0;
    if (dv_end.n.neg) begin
      if (dv_end.n.ovf || mn_q > NEG_LIM) begin
        tn = T_MIN;
        sn = 1'b1;
      end else begin
        tn = -mn_q[WORD_BITS-1:0];
      end
    end else if (dv_end.n.ovf || dv_end.n.q[WORD_BITS-1]) begin
      tn = T_MAX;
      sn = 1'b1;
    end else begin
      tn = dv_end.n.q;
    end
  end

  always_comb begin
    sf = 1'b0;
    if (dv_end.f.neg) begin
      if (dv_end.f.ovf || mf_q > NEG_LIM) begin
        tf = T_MIN;
        sf = 1'b1;
      end else begin
        tf = -mf_q[WORD_BITS-1:0];
      end
    end else if (dv_end.f.ovf || dv_end.f.q[WORD_BITS-1]) begin
      tf = T_MAX;
      sf = 1'b1;
    end else begin
      tf = dv_end.f.q;
    end
  end

  logic                        out_valid_r;
  logic                        out_hit_r, out_degenerate_r, out_saturated_r;
  logic signed [WORD_BITS-1:0] out_t_near_r, out_t_far_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_end.vld;
    end
  end

  always_ff @(posedge clk) begin
    out_hit_r        <= hit;
    out_degenerate_r <= dv_end.degen;
    out_saturated_r  <= hit && (sn || sf);
    out_t_near_r     <= hit ? tn : '0;
    out_t_far_r      <= hit ? tf : '0;
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_degenerate = out_degenerate_r;
  assign out_saturated  = out_saturated_r;
  assign out_t_near     = out_t_near_r;
  assign out_t_far      = out_t_far_r;

  a_degen_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> !out_hit && !out_saturated)
    else $error("degenerate ray reported as hit");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_t_near == '0 && out_t_far == '0 && !out_saturated)
    else $error("miss with nonzero roots");

  a_root_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> out_t_near <= out_t_far)
    else $error("near root beyond far root");

endmodule

FILE: rtl/core/rusi_quad.sv
// quadratic coefficients and discriminant, six pipeline stages
module rusi_quad (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          vld_i,
  input  rusi_pkg::ray_t ray_i,
  output rusi_pkg::sq_t  sq_o
);
  import rusi_pkg::*;

  localparam logic signed [H_W-1:0] ONE_SQ = H_W'(1) << (2 * FRAC_BITS);
  localparam int HW = WORD_BITS;

  logic [5:0] vld_r;

  // stage 1: the nine products
  logic signed [2*WORD_BITS-1:0] dd_r [3];
  logic signed [2*WORD_BITS-1:0] do_r [3];
  logic signed [2*WORD_BITS-1:0] oo_r [3];
  // stage 2: sums
  logic [A_W-1:0]        a2_r;
  logic signed [H_W-1:0] h2_r, c2_r;
  // stage 3: magnitudes
  logic [A_W-1:0]        a3_r, ha3_r, ca3_r;
  logic signed [H_W-1:0] h3_r;
  logic                  cneg3_r, degen3_r;
  logic signed [H_W-1:0] h_abs, c_abs;
  // stage 4: partial products
  logic [A_W-1:0]        hll_r, hlh_r, hhh_r, all_r, alh_r, ahl_r, ahh_r, a4_r;
  logic signed [H_W-1:0] h4_r;
  logic                  cneg4_r, degen4_r;
  // stage 5: full squares
  logic [D2_W-1:0]       hsq5_r, ac5_r;
  logic [A_W-1:0]        a5_r;
  logic signed [H_W-1:0] h5_r;
  logic                  cneg5_r, degen5_r;
  // stage 6: discriminant
  logic [D2_W:0]         disc_nxt;
  sq_t                   sq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[4:0], vld_i};
    end
  end

  assign h_abs = h2_r[H_W-1] ? -h2_r : h2_r;
  assign c_abs = c2_r[H_W-1] ? -c2_r : c2_r;
  assign disc_nxt = cneg5_r ? ({1'b0, hsq5_r} + {1'b0, ac5_r})
                            : ({1'b0, hsq5_r} - {1'b0, ac5_r});

  always_ff @(posedge clk) begin
    dd_r[0] <= ray_i.dx * ray_i.dx;
    dd_r[1] <= ray_i.dy * ray_i.dy;
    dd_r[2] <= ray_i.dz * ray_i.dz;
    do_r[0] <= ray_i.dx * ray_i.ox;
    do_r[1] <= ray_i.dy * ray_i.oy;
    do_r[2] <= ray_i.dz * ray_i.oz;
    oo_r[0] <= ray_i.ox * ray_i.ox;
    oo_r[1] <= ray_i.oy * ray_i.oy;
    oo_r[2] <= ray_i.oz * ray_i.oz;

    a2_r <= A_W'(dd_r[0]) + A_W'(dd_r[1]) + A_W'(dd_r[2]);
    h2_r <= H_W'(do_r[0]) + H_W'(do_r[1]) + H_W'(do_r[2]);
    c2_r <= H_W'(oo_r[0]) + H_W'(oo_r[1]) + H_W'(oo_r[2]) - ONE_SQ;

    a3_r     <= a2_r;
    h3_r     <= h2_r;
    ha3_r    <= h_abs[A_W-1:0];
    ca3_r    <= c_abs[A_W-1:0];
    cneg3_r  <= c2_r[H_W-1];
    degen3_r <= (a2_r == '0);

    hll_r    <= ha3_r[HW-1:0] * ha3_r[HW-1:0];
    hlh_r    <= ha3_r[HW-1:0] * ha3_r[A_W-1:HW];
    hhh_r    <= ha3_r[A_W-1:HW] * ha3_r[A_W-1:HW];
    all_r    <= a3_r[HW-1:0] * ca3_r[HW-1:0];
    alh_r    <= a3_r[HW-1:0] * ca3_r[A_W-1:HW];
    ahl_r    <= a3_r[A_W-1:HW] * ca3_r[HW-1:0];
    ahh_r    <= a3_r[A_W-1:HW] * ca3_r[A_W-1:HW];
    a4_r     <= a3_r;
    h4_r     <= h3_r;
    cneg4_r  <= cneg3_r;
    degen4_r <= degen3_r;

    hsq5_r   <= {hhh_r, hll_r} + (D2_W'(hlh_r) << (HW + 1));
    ac5_r    <= {ahh_r, all_r} + (D2_W'(alh_r) << HW) + (D2_W'(ahl_r) << HW);
    a5_r     <= a4_r;
    h5_r     <= h4_r;
    cneg5_r  <= cneg4_r;
    degen5_r <= degen4_r;

    sq_r.rem   <= '0;
    sq_r.root  <= '0;
    sq_r.x     <= {disc_nxt[D2_W-1:0], (2 * FRAC_BITS)'(0)};
    sq_r.h     <= h5_r;
    sq_r.a     <= a5_r;
    sq_r.degen <= degen5_r;
    sq_r.miss  <= !cneg5_r && disc_nxt[D2_W];
    sq_r.vld   <= 1'b0;
  end

  always_comb begin
    sq_o     = sq_r;
    sq_o.vld = vld_r[5];
  end

endmodule

FILE: rtl/core/rusi_sqrt_cell.sv
// one square root cell: retires one root bit per request
module rusi_sqrt_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  rusi_pkg::sq_t c_i,
  output rusi_pkg::sq_t c_o
);
  import rusi_pkg::*;

  logic [REM_W+1:0] t;
  logic [REM_W+1:0] trial;
  sq_t              nxt;
  sq_t              dat_r;
  logic             vld_r;

  always_comb begin
    nxt   = c_i;
    t     = {c_i.rem, c_i.x[X_W-1 -: 2]};
    trial = (REM_W + 2)'({c_i.root, 2'b01});
    if (t >= trial) begin
      nxt.rem  = REM_W'(t - trial);
      nxt.root = {c_i.root[S_W-2:0], 1'b1};
    end else begin
      nxt.rem  = t[REM_W-1:0];
      nxt.root = {c_i.root[S_W-2:0], 1'b0};
    end
    nxt.x = c_i.x << 2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= c_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    dat_r <= nxt;
  end

  always_comb begin
    c_o     = dat_r;
    c_o.vld = vld_r;
  end

endmodule

FILE: rtl/core/rusi_div_cell.sv
// one division cell: one quotient bit for the near and the far root
module rusi_div_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  rusi_pkg::dv_t c_i,
  output rusi_pkg::dv_t c_o
);
  import rusi_pkg::*;

  dv_t  nxt;
  dv_t  dat_r;
  logic vld_r;

  always_comb begin
    nxt   = c_i;
    nxt.n = div_step(c_i.n, c_i.a);
    nxt.f = div_step(c_i.f, c_i.a);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= c_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    dat_r <= nxt;
  end

  always_comb begin
    c_o     = dat_r;
    c_o.vld = vld_r;
  end

endmodule

FILE: bench/tb_top.sv
// testbench for the ray / unit sphere intersect pipeline
`timescale 1ns / 1ps

module tb_top;
  import rusi_pkg::*;

  typedef logic signed [255:0] wide_t;

  typedef struct {
    logic                        hit;
    logic signed [WORD_BITS-1:0] t_near;
    logic signed [WORD_BITS-1:0] t_far;
    logic                        degen;
    logic                        sat;
  } isect_t;

  localparam int LATENCY   = 122;
  localparam int MAX_CYCLE = 400000;

  logic                        clk;
  logic                        rst_n;
  logic                        start;
  logic                        busy;
  logic signed [WORD_BITS-1:0] in_origin_x, in_origin_y, in_origin_z;
  logic signed [WORD_BITS-1:0] in_dir_x, in_dir_y, in_dir_z;
  logic                        out_valid;
  logic                        out_hit;
  logic signed [WORD_BITS-1:0] out_t_near, out_t_far;
  logic                        out_degenerate;
  logic                        out_saturated;

  ray_t   pending_rays[$];
  isect_t expected_isects[$];
  int     fail_count;
  int     accepted;
  int     cycle_count;
  bit     stim_done;

  ray_unit_sphere_intersect dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_origin_x(in_origin_x), .in_origin_y(in_origin_y), .in_origin_z(in_origin_z),
    .in_dir_x(in_dir_x), .in_dir_y(in_dir_y), .in_dir_z(in_dir_z),
    .out_valid(out_valid), .out_hit(out_hit), .out_t_near(out_t_near),
    .out_t_far(out_t_far), .out_degenerate(out_degenerate),
    .out_saturated(out_saturated)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // append one ray to the pending requests
  task automatic add_ray(ray_t r);
    pending_rays = {pending_rays, r};
  endtask

  // floor division, divisor positive
  function automatic wide_t floor_div(wide_t n, wide_t d);
    wide_t q;
    q = n / d;
    if (n < 0 && q * d != n) q = q - 1;
    return q;
  endfunction

  function automatic logic signed [WORD_BITS-1:0] clamp_root(wide_t v, inout logic sat);
    wide_t hi, lo;
    hi = (wide_t'(1) <<< (WORD_BITS - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      sat = 1'b1;
      return hi[WORD_BITS-1:0];
    end
    if (v < lo) begin
      sat = 1'b1;
      return lo[WORD_BITS-1:0];
    end
    return v[WORD_BITS-1:0];
  endfunction

  function automatic isect_t sphere_isect(ray_t r);
    wide_t  ox, oy, oz, dx, dy, dz;
    wide_t  a, h, c, disc, x, s, cand, hs;
    isect_t e;
    ox = r.ox; oy = r.oy; oz = r.oz;
    dx = r.dx; dy = r.dy; dz = r.dz;
    e = '{1'b0, '0, '0, 1'b0, 1'b0};
    a = dx * dx + dy * dy + dz * dz;
    h = dx * ox + dy * oy + dz * oz;
    c = ox * ox + oy * oy + oz * oz - (wide_t'(1) <<< (2 * FRAC_BITS));
    if (a == 0) begin
      e.degen = 1'b1;
    end else begin
      disc = h * h - a * c;
      if (disc >= 0) begin
        e.hit = 1'b1;
        x = disc <<< (2 * FRAC_BITS);
        s = 0;
        for (int k = 126; k >= 0; k--) begin
          cand = s | (wide_t'(1) <<< k);
          if (cand * cand <= x) s = cand;
        end
        hs = -(h <<< FRAC_BITS);
        e.t_near = clamp_root(floor_div(hs - s, a), e.sat);
        e.t_far  = clamp_root(floor_div(hs + s, a), e.sat);
      end
    end
    return e;
  endfunction

  function automatic logic signed [WORD_BITS-1:0] rand_word(int kind);
    case (kind)
      0: return $urandom();
      1: return $signed($urandom_range(0, 1 << 19)) - (1 << 18);  // within +-4.0
      2: return $signed($urandom_range(0, 64)) - 32;              // tiny
      default: return $signed($urandom_range(0, 1 << 17)) - (1 << 16);
    endcase
  endfunction

  function automatic ray_t rand_ray();
    ray_t r;
    int   sel;
    sel = $urandom_range(0, 99);
    if (sel < 20) begin
      r = '{rand_word(0), rand_word(0), rand_word(0), rand_word(0), rand_word(0),
            rand_word(0)};
    end else if (sel < 30) begin
      r = '{rand_word(1), rand_word(1), rand_word(1), rand_word(2), rand_word(2),
            rand_word(2)};
    end else if (sel < 35) begin
      r = '{rand_word(1), rand_word(1), rand_word(1), '0, '0, '0};
    end else begin
      // well-formed ray from a few units out, aimed at the sphere about half of the time
      r = '{rand_word(1), rand_word(1), rand_word(1), rand_word(3), rand_word(3),
            rand_word(3)};
      if ($urandom_range(0, 1)) begin
        r.dx = -(r.ox >>> 2);
        r.dy = -(r.oy >>> 2) + (rand_word(3) >>> 3);
        r.dz = -(r.oz >>> 2);
      end
    end
    return r;
  endfunction

  // driver: request presented on the falling edge
  always @(negedge clk) begin
    if (!rst_n || pending_rays.size() == 0) begin
      start <= 1'b0;
    end else if ((accepted > 600 && accepted < 800) || $urandom_range(0, 99) >= 29) begin
      start       <= 1'b1;
      in_origin_x <= pending_rays[0].ox;
      in_origin_y <= pending_rays[0].oy;
      in_origin_z <= pending_rays[0].oz;
      in_dir_x    <= pending_rays[0].dx;
      in_dir_y    <= pending_rays[0].dy;
      in_dir_z    <= pending_rays[0].dz;
    end else begin
      start <= 1'b0;
    end
  end

  // monitor: check results, then record taken requests
  always @(posedge clk) begin
    isect_t e;
    ray_t   r;
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLE) begin
      $display("%0t timeout", $time);
      $display("status: fail");
      $finish;
    end
    if (rst_n && out_valid) begin
      if (expected_isects.size() == 0) begin
        $display("%0t unexpected result hit=%0b", $time, out_hit);
        fail_count <= fail_count + 1;
      end else begin
        e = expected_isects.pop_front();
        if (out_hit !== e.hit || out_t_near !== e.t_near || out_t_far !== e.t_far ||
            out_degenerate !== e.degen || out_saturated !== e.sat) begin
          $display("%0t mismatch exp hit=%0b near=%0d far=%0d degen=%0b sat=%0b",
                   $time, e.hit, e.t_near, e.t_far, e.degen, e.sat);
          $display("%0t          got hit=%0b near=%0d far=%0d degen=%0b sat=%0b",
                   $time, out_hit, out_t_near, out_t_far, out_degenerate, out_saturated);
          fail_count <= fail_count + 1;
        end
      end
    end
    if (rst_n && start && !busy) begin
      r = pending_rays.pop_front();
      expected_isects = {expected_isects, sphere_isect(r)};
      accepted <= accepted + 1;
    end
  end

  initial begin
    logic signed [WORD_BITS-1:0] mx, mn, one;
    mx  = {1'b0, {(WORD_BITS-1){1'b1}}};
    mn  = {1'b1, {(WORD_BITS-1){1'b0}}};
    one = 1 <<< FRAC_BITS;
    rst_n = 1'b0;
    start = 1'b0;
    in_origin_x = '0; in_origin_y = '0; in_origin_z = '0;
    in_dir_x = '0; in_dir_y = '0; in_dir_z = '0;
    fail_count = 0;
    accepted = 0;
    cycle_count = 0;
    // directed: zero direction, center origin, tangent, miss, tiny direction, extremes
    add_ray(ray_t'{one, one, one, '0, '0, '0});
    add_ray(ray_t'{'0, '0, '0, one, '0, '0});
    add_ray(ray_t'{-2 * one, '0, '0, one, '0, '0});
    add_ray(ray_t'{-2 * one, one, '0, one, '0, '0});
    add_ray(ray_t'{-2 * one, 2 * one, '0, one, '0, '0});
    add_ray(ray_t'{-2 * one, '0, '0, 1, '0, '0});
    add_ray(ray_t'{'0, '0, '0, '0, '0, 1});
    add_ray(ray_t'{mx, mx, mx, mx, mx, mx});
    add_ray(ray_t'{mn, mn, mn, mn, mn, mn});
    add_ray(ray_t'{mx, mn, mx, mn, mx, mn});
    add_ray(ray_t'{mn, '0, '0, mx, '0, '0});
    add_ray(ray_t'{'0, '0, '0, mn, mn, mn});
    add_ray(ray_t'{-1, -1, -1, -1, -1, -1});
    add_ray(ray_t'{'0, '0, mx, '0, '0, mn});
    add_ray(ray_t'{one >>> 1, '0, '0, '0, -one, '0});
    add_ray(ray_t'{'0, '0, '0, '0, '0, '0});
    for (int i = 0; i < 1400; i++) add_ray(rand_ray());
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_rays.size() == 0 && expected_isects.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0 && expected_isects.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
